>>> sv/arpl_pkg.sv
`default_nettype none

package arpl_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] DROP_MAX         = 16'hFFFF;
    localparam logic [7:0]  IP_OCTET_ZERO    = 8'h00;

    // One table entry as it is held in the slot memory.
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] first_sec;
        logic [19:0] first_usec;
        logic [31:0] last_sec;
        logic [19:0] last_usec;
    } slot_t;

    // One emitted host record.
    typedef struct packed {
        slot_t       slot;
        logic [15:0] drops;
        logic        final_entry;
    } host_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_SCAN,
        ST_WRITE,
        ST_FLUSH_RD,
        ST_FLUSH_EMIT
    } state_t;

    // A pair is learned only with a nonzero top IP octet and a MAC that is neither all zeros nor all ones.
    function automatic logic pair_ok(input logic [31:0] ip, input logic [47:0] mac);
        return (ip[31:24] != IP_OCTET_ZERO) && (mac != '0) && (mac != '1);
    endfunction

endpackage

`default_nettype wire

>>> sv/arpl_mem.sv
`default_nettype none

module arpl_mem
    import arpl_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire slot_t         wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output slot_t              rd_data
);

    slot_t slot_mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/arpl_outreg.sv
`default_nettype none

module arpl_outreg
    import arpl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  emit,
    input  wire host_t emit_data,
    output logic       load_ok,
    output logic       host_valid,
    input  wire logic  host_stall,
    output host_t      host_data
);

    logic  valid_reg;
    logic  valid_next;
    host_t data_reg;

    // The register may be refilled in the same cycle its transaction completes.
    assign load_ok = !valid_reg || !host_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (!host_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= emit_data;
        end
    end

    assign host_valid = valid_reg;
    assign host_data  = data_reg;

endmodule

`default_nettype wire

>>> sv/arpl_ctrl.sv
`default_nettype none

module arpl_ctrl
    import arpl_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int IW = $clog2(DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pkt_valid,
    output logic               pkt_stall,
    input  wire logic          mode,
    input  wire logic [15:0]   hw_type,
    input  wire logic [15:0]   proto_type,
    input  wire logic [47:0]   sender_mac,
    input  wire logic [31:0]   sender_ip,
    input  wire logic [47:0]   target_mac,
    input  wire logic [31:0]   target_ip,
    input  wire logic [31:0]   time_sec,
    input  wire logic [19:0]   time_usec,
    output logic               mem_wr_en,
    output logic [AW-1:0]      mem_wr_addr,
    output slot_t              mem_wr_data,
    output logic               mem_rd_en,
    output logic [AW-1:0]      mem_rd_addr,
    input  wire slot_t         mem_rd_data,
    output logic               emit,
    output host_t              emit_data,
    input  wire logic          load_ok
);

    state_t          state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_idx_reg, pend_idx_next;
    logic            free_found_reg, free_found_next;
    logic [AW-1:0]   free_idx_reg, free_idx_next;
    logic            is_hit_reg, is_hit_next;
    logic [AW-1:0]   wr_idx_reg, wr_idx_next;
    logic [31:0]     hit_first_sec_reg, hit_first_sec_next;
    logic [19:0]     hit_first_usec_reg, hit_first_usec_next;
    logic            pair_sel_reg, pair_sel_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [15:0]     drop_reg, drop_next;

    logic [47:0]     smac_reg, tmac_reg;
    logic [31:0]     sip_reg, tip_reg;
    logic [31:0]     sec_reg;
    logic [19:0]     usec_reg;

    logic            accept;
    logic            pkt_ok;
    logic [AW-1:0]   slot_idx;
    logic            idx_at_end;
    logic [47:0]     cur_mac;
    logic [31:0]     cur_ip;
    logic            cur_ok;
    logic            scan_issue;
    logic            scan_hit;
    logic            scan_done;
    logic [DEPTH-1:0] valid_above;
    logic            keep_first;

    assign pkt_stall  = (state_reg != ST_IDLE);
    assign accept     = pkt_valid && (state_reg == ST_IDLE);
    assign pkt_ok     = (hw_type == HW_TYPE_ETHERNET) && (proto_type == PROTO_TYPE_IPV4);
    assign slot_idx   = idx_reg[AW-1:0];
    assign idx_at_end = (idx_reg == IW'(DEPTH));
    assign cur_mac    = pair_sel_reg ? tmac_reg : smac_reg;
    assign cur_ip     = pair_sel_reg ? tip_reg : sip_reg;
    assign cur_ok     = pair_ok(cur_ip, cur_mac);

    // The scan is pipelined: a slot is read in one cycle and compared in the next.
    assign scan_issue = (state_reg == ST_SCAN) && !idx_at_end;
    assign scan_hit   = (state_reg == ST_SCAN) && pend_reg && valid_reg[pend_idx_reg]
                        && (mem_rd_data.ip == cur_ip) && (mem_rd_data.mac == cur_mac);
    assign scan_done  = (state_reg == ST_SCAN) && idx_at_end && !pend_reg;

    assign valid_above = valid_reg >> slot_idx;
    assign keep_first  = is_hit_reg && (hit_first_sec_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        state_next = ST_FLUSH_RD;
                    end
                    else if (pkt_ok)
                    begin
                        state_next = ST_PAIR;
                    end
                end
            end
            ST_PAIR:
            begin
                if (cur_ok)
                begin
                    state_next = ST_SCAN;
                end
                else if (pair_sel_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_WRITE;
                end
                else if (scan_done)
                begin
                    if (free_found_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = pair_sel_reg ? ST_IDLE : ST_PAIR;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = pair_sel_reg ? ST_IDLE : ST_PAIR;
            end
            ST_FLUSH_RD:
            begin
                if (idx_at_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (valid_reg[slot_idx])
                begin
                    state_next = ST_FLUSH_EMIT;
                end
            end
            ST_FLUSH_EMIT:
            begin
                if (load_ok)
                begin
                    state_next = ST_FLUSH_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next            = idx_reg;
        pend_next           = pend_reg;
        pend_idx_next       = pend_idx_reg;
        free_found_next     = free_found_reg;
        free_idx_next       = free_idx_reg;
        is_hit_next         = is_hit_reg;
        wr_idx_next         = wr_idx_reg;
        hit_first_sec_next  = hit_first_sec_reg;
        hit_first_usec_next = hit_first_usec_reg;
        pair_sel_next       = pair_sel_reg;
        valid_next          = valid_reg;
        drop_next           = drop_reg;
        mem_rd_en           = 1'b0;
        mem_wr_en           = 1'b0;
        emit                = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = '0;
                    pair_sel_next = 1'b0;
                end
            end
            ST_PAIR:
            begin
                idx_next        = '0;
                pend_next       = 1'b0;
                free_found_next = 1'b0;
                if (!cur_ok)
                begin
                    pair_sel_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                pend_next     = scan_issue;
                pend_idx_next = slot_idx;
                if (scan_issue)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + IW'(1);
                    if (!valid_reg[slot_idx] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = slot_idx;
                    end
                end
                if (scan_hit)
                begin
                    is_hit_next         = 1'b1;
                    wr_idx_next         = pend_idx_reg;
                    hit_first_sec_next  = mem_rd_data.first_sec;
                    hit_first_usec_next = mem_rd_data.first_usec;
                end
                else if (scan_done)
                begin
                    is_hit_next = 1'b0;
                    wr_idx_next = free_idx_reg;
                    if (!free_found_reg)
                    begin
                        // Table full: the pair is lost.
                        if (drop_reg != DROP_MAX)
                        begin
                            drop_next = drop_reg + 16'd1;
                        end
                        pair_sel_next = 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_wr_en              = 1'b1;
                valid_next[wr_idx_reg] = 1'b1;
                pair_sel_next          = 1'b1;
            end
            ST_FLUSH_RD:
            begin
                if (idx_at_end)
                begin
                    valid_next = '0;
                    drop_next  = '0;
                end
                else if (valid_reg[slot_idx])
                begin
                    mem_rd_en = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_FLUSH_EMIT:
            begin
                emit = load_ok;
                if (load_ok)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mem_rd_addr = slot_idx;
    assign mem_wr_addr = wr_idx_reg;

    always_comb
    begin
        mem_wr_data.ip        = cur_ip;
        mem_wr_data.mac       = cur_mac;
        mem_wr_data.first_sec = keep_first ? hit_first_sec_reg : sec_reg;
        mem_wr_data.first_usec = keep_first ? hit_first_usec_reg : usec_reg;
        mem_wr_data.last_sec  = sec_reg;
        mem_wr_data.last_usec = usec_reg;
    end

    always_comb
    begin
        emit_data.slot        = mem_rd_data;
        emit_data.drops       = drop_reg;
        emit_data.final_entry = ~|valid_above[DEPTH-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            idx_reg            <= '0;
            pend_reg           <= 1'b0;
            pend_idx_reg       <= '0;
            free_found_reg     <= 1'b0;
            free_idx_reg       <= '0;
            is_hit_reg         <= 1'b0;
            wr_idx_reg         <= '0;
            hit_first_sec_reg  <= '0;
            hit_first_usec_reg <= '0;
            pair_sel_reg       <= 1'b0;
            valid_reg          <= '0;
            drop_reg           <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            idx_reg            <= idx_next;
            pend_reg           <= pend_next;
            pend_idx_reg       <= pend_idx_next;
            free_found_reg     <= free_found_next;
            free_idx_reg       <= free_idx_next;
            is_hit_reg         <= is_hit_next;
            wr_idx_reg         <= wr_idx_next;
            hit_first_sec_reg  <= hit_first_sec_next;
            hit_first_usec_reg <= hit_first_usec_next;
            pair_sel_reg       <= pair_sel_next;
            valid_reg          <= valid_next;
            drop_reg           <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smac_reg <= sender_mac;
            sip_reg  <= sender_ip;
            tmac_reg <= target_mac;
            tip_reg  <= target_ip;
            sec_reg  <= time_sec;
            usec_reg <= time_usec;
        end
    end

endmodule

`default_nettype wire

>>> sv/arp_host_learning_table.sv
// Learns (IPv4, MAC) host pairs from ARP packets into a table of TABLE_DEPTH slots held
// in one synchronous memory, with a valid bit per slot in flip-flops. A packet transaction
// (mode 0) with hardware type 1 and protocol 0x0800 records the sender pair and then the
// target pair; each pair is found or allocated by a linear scan of the memory that reads
// one slot per cycle, and the block stalls new input until both pairs are done. A flush
// transaction (mode 1) emits every valid slot in slot order, the last one marked by
// final_entry, and then clears the table and the drop counter; it skips empty slots,
// reads each valid slot and hands it to the output register once that can take it, so
// an output stall holds the flush. No memory clearing pass is needed after reset. The
// block accepts a new transaction whenever it is idle, even while the last result still
// waits in the output register.
`default_nettype none

module arp_host_learning_table
    import arpl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pkt_valid,
    output logic             pkt_stall,
    input  wire logic        mode,
    input  wire logic [15:0] hw_type,
    input  wire logic [15:0] proto_type,
    input  wire logic [47:0] sender_mac,
    input  wire logic [31:0] sender_ip,
    input  wire logic [47:0] target_mac,
    input  wire logic [31:0] target_ip,
    input  wire logic [31:0] time_sec,
    input  wire logic [19:0] time_usec,
    output logic             host_valid,
    input  wire logic        host_stall,
    output logic [47:0]      host_mac,
    output logic [31:0]      host_ip,
    output logic [31:0]      first_sec,
    output logic [19:0]      first_usec,
    output logic [31:0]      last_sec,
    output logic [19:0]      last_usec,
    output logic [15:0]      drops,
    output logic             final_entry
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    slot_t         mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    slot_t         mem_rd_data;
    logic          emit;
    host_t         emit_data;
    logic          load_ok;
    host_t         host_data;

    arpl_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_stall   (pkt_stall),
        .mode        (mode),
        .hw_type     (hw_type),
        .proto_type  (proto_type),
        .sender_mac  (sender_mac),
        .sender_ip   (sender_ip),
        .target_mac  (target_mac),
        .target_ip   (target_ip),
        .time_sec    (time_sec),
        .time_usec   (time_usec),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .emit        (emit),
        .emit_data   (emit_data),
        .load_ok     (load_ok)
    );

    arpl_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    arpl_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .emit_data  (emit_data),
        .load_ok    (load_ok),
        .host_valid (host_valid),
        .host_stall (host_stall),
        .host_data  (host_data)
    );

    assign host_mac    = host_data.slot.mac;
    assign host_ip     = host_data.slot.ip;
    assign first_sec   = host_data.slot.first_sec;
    assign first_usec  = host_data.slot.first_usec;
    assign last_sec    = host_data.slot.last_sec;
    assign last_usec   = host_data.slot.last_usec;
    assign drops       = host_data.drops;
    assign final_entry = host_data.final_entry;

endmodule

`default_nettype wire

>>> sim/arp_host_learning_table_tb.sv
`timescale 1ns / 1ps

module arp_host_learning_table_tb;
    import arpl_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int POOL_SIZE = 48;

    typedef struct {
        logic        mode;
        logic [15:0] hw;
        logic [15:0] proto;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [47:0] tmac;
        logic [31:0] tip;
        logic [31:0] sec;
        logic [19:0] usec;
        int          idle_pct;
        int          stall_pct;
        int          hold;
        bit          drain;
    } arp_item_t;

    logic        clk;
    logic        rst_n;
    logic        pkt_valid = 1'b0;
    logic        pkt_stall;
    logic        mode = 1'b0;
    logic [15:0] hw_type = '0;
    logic [15:0] proto_type = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [47:0] target_mac = '0;
    logic [31:0] target_ip = '0;
    logic [31:0] time_sec = '0;
    logic [19:0] time_usec = '0;
    logic        host_valid;
    logic        host_stall = 1'b0;
    logic [47:0] host_mac;
    logic [31:0] host_ip;
    logic [31:0] first_sec;
    logic [19:0] first_usec;
    logic [31:0] last_sec;
    logic [19:0] last_usec;
    logic [15:0] drops;
    logic        final_entry;

    arp_host_learning_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_stall   (pkt_stall),
        .mode        (mode),
        .hw_type     (hw_type),
        .proto_type  (proto_type),
        .sender_mac  (sender_mac),
        .sender_ip   (sender_ip),
        .target_mac  (target_mac),
        .target_ip   (target_ip),
        .time_sec    (time_sec),
        .time_usec   (time_usec),
        .host_valid  (host_valid),
        .host_stall  (host_stall),
        .host_mac    (host_mac),
        .host_ip     (host_ip),
        .first_sec   (first_sec),
        .first_usec  (first_usec),
        .last_sec    (last_sec),
        .last_usec   (last_usec),
        .drops       (drops),
        .final_entry (final_entry)
    );

    // Stimulus and checking state.
    arp_item_t   item_q[$];
    arp_item_t   cur_item;
    bit          item_held = 0;
    bit          pkt_taken = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          err_count = 0;
    int          shown_count = 0;
    int          gen_idle_pct = 0;
    int          gen_stall_pct = 0;
    host_t       host_expect_q[$];

    // Predicted table contents.
    bit          known_valid[DEPTH];
    slot_t       known_slot[DEPTH];
    logic [15:0] known_drops = '0;

    logic [31:0] pool_ip[POOL_SIZE];
    logic [47:0] pool_mac[POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic bit learnable(logic [31:0] ip, logic [47:0] mac);
        return (ip[31:24] != 8'h00) && (mac != 48'h0) && (mac != {48{1'b1}});
    endfunction

    function automatic void learn_pair(logic [31:0] ip, logic [47:0] mac,
                                       logic [31:0] sec, logic [19:0] usec);
        int hit;
        int free_idx;
        hit = -1;
        free_idx = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (known_valid[i])
            begin
                if (hit < 0 && known_slot[i].ip == ip && known_slot[i].mac == mac)
                    hit = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (hit < 0)
        begin
            if (free_idx < 0)
            begin
                if (known_drops != DROP_MAX)
                    known_drops++;
                return;
            end
            hit = free_idx;
            known_valid[hit] = 1'b1;
            known_slot[hit] = '0;
            known_slot[hit].ip = ip;
            known_slot[hit].mac = mac;
        end
        if (known_slot[hit].first_sec == '0)
        begin
            known_slot[hit].first_sec = sec;
            known_slot[hit].first_usec = usec;
        end
        known_slot[hit].last_sec = sec;
        known_slot[hit].last_usec = usec;
    endfunction

    function automatic void flush_hosts();
        int    last_idx;
        host_t h;
        last_idx = -1;
        for (int i = 0; i < DEPTH; i++)
            if (known_valid[i])
                last_idx = i;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (known_valid[i])
            begin
                h.slot = known_slot[i];
                h.drops = known_drops;
                h.final_entry = (i == last_idx);
                host_expect_q.push_back(h);
            end
            known_valid[i] = 1'b0;
        end
        known_drops = '0;
    endfunction

    function automatic void absorb_item(arp_item_t it);
        if (it.mode == MODE_FLUSH)
            flush_hosts();
        else if (it.hw == HW_TYPE_ETHERNET && it.proto == PROTO_TYPE_IPV4)
        begin
            if (learnable(it.sip, it.smac))
                learn_pair(it.sip, it.smac, it.sec, it.usec);
            if (learnable(it.tip, it.tmac))
                learn_pair(it.tip, it.tmac, it.sec, it.usec);
        end
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        err_count++;
        if (shown_count < 10)
        begin
            shown_count++;
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        end
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            note_mismatch(what, want, got);
    endfunction

    function automatic arp_item_t arp_packet(logic [15:0] hw, logic [15:0] proto,
                                             logic [47:0] smac, logic [31:0] sip,
                                             logic [47:0] tmac, logic [31:0] tip,
                                             logic [31:0] sec, logic [19:0] usec);
        arp_item_t it;
        it.mode = MODE_PACKET;
        it.hw = hw;
        it.proto = proto;
        it.smac = smac;
        it.sip = sip;
        it.tmac = tmac;
        it.tip = tip;
        it.sec = sec;
        it.usec = usec;
        it.idle_pct = gen_idle_pct;
        it.stall_pct = gen_stall_pct;
        it.hold = 0;
        it.drain = 0;
        return it;
    endfunction

    // The other fields of a flush carry junk, since the block must ignore them.
    function automatic arp_item_t flush_request();
        arp_item_t it;
        it = arp_packet(16'($urandom), 16'($urandom), rand48(), $urandom, rand48(),
                        $urandom, $urandom, 20'($urandom));
        it.mode = MODE_FLUSH;
        return it;
    endfunction

    function automatic void pick_pair(output logic [47:0] mac, output logic [31:0] ip);
        int k;
        k = $urandom_range(0, POOL_SIZE - 1);
        mac = pool_mac[k];
        ip = pool_ip[k];
        case ($urandom_range(0, 29))
            0: ip[31:24] = 8'h00;
            1: mac = 48'h0;
            2: mac = {48{1'b1}};
            default: ;
        endcase
    endfunction

    function automatic arp_item_t random_packet();
        arp_item_t   it;
        logic [47:0] smac;
        logic [47:0] tmac;
        logic [31:0] sip;
        logic [31:0] tip;
        int          kind;
        logic [31:0] sec;
        pick_pair(smac, sip);
        pick_pair(tmac, tip);
        sec = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
        kind = $urandom_range(0, 99);
        if (kind < 78)
            it = arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, smac, sip, tmac, tip,
                            sec, 20'($urandom));
        else if (kind < 84)
            it = arp_packet(HW_TYPE_ETHERNET, 16'($urandom), smac, sip, tmac, tip, sec,
                            20'($urandom));
        else if (kind < 90)
            it = arp_packet(16'($urandom), PROTO_TYPE_IPV4, smac, sip, tmac, tip, sec,
                            20'($urandom));
        else
            it = arp_packet(16'($urandom), 16'($urandom), rand48(), $urandom, rand48(),
                            $urandom, $urandom, 20'($urandom));
        return it;
    endfunction

    // Driver: presents one transaction at a time and holds it until it is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_held && pkt_taken)
                item_held = 0;
            if (!item_held && item_q.size() != 0)
            begin
                if (!(item_q[0].drain && host_expect_q.size() != 0) &&
                    $urandom_range(0, 99) >= item_q[0].idle_pct)
                begin
                    cur_item = item_q.pop_front();
                    mode <= cur_item.mode;
                    hw_type <= cur_item.hw;
                    proto_type <= cur_item.proto;
                    sender_mac <= cur_item.smac;
                    sender_ip <= cur_item.sip;
                    target_mac <= cur_item.tmac;
                    target_ip <= cur_item.tip;
                    time_sec <= cur_item.sec;
                    time_usec <= cur_item.usec;
                    stall_pct = cur_item.stall_pct;
                    if (cur_item.hold > 0)
                        hold_req = cur_item.hold;
                    item_held = 1;
                end
            end
            pkt_valid <= item_held;
        end
    end

    // Receiver: random stalls, plus a long hold-off when the driver asks for one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                host_stall <= 1'b1;
            end
            else if (hold_req > 0)
            begin
                hold_left = hold_req - 1;
                hold_req = 0;
                host_stall <= 1'b1;
            end
            else
                host_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor: predicts on every accepted input transaction and checks every result.
    always @(posedge clk)
    begin
        host_t want;
        bit    host_taken;
        if (rst_n)
        begin
            pkt_taken = pkt_valid && !pkt_stall;
            host_taken = host_valid && !host_stall;
            if (pkt_taken)
                absorb_item(cur_item);
            if (host_taken)
            begin
                if (host_expect_q.size() == 0)
                begin
                    err_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("%0t: unexpected host record ip %h mac %h", $realtime,
                                 host_ip, host_mac);
                    end
                end
                else
                begin
                    want = host_expect_q.pop_front();
                    check_field("host_mac", 64'(want.slot.mac), 64'(host_mac));
                    check_field("host_ip", 64'(want.slot.ip), 64'(host_ip));
                    check_field("first_sec", 64'(want.slot.first_sec), 64'(first_sec));
                    check_field("first_usec", 64'(want.slot.first_usec), 64'(first_usec));
                    check_field("last_sec", 64'(want.slot.last_sec), 64'(last_sec));
                    check_field("last_usec", 64'(want.slot.last_usec), 64'(last_usec));
                    check_field("drops", 64'(want.drops), 64'(drops));
                    check_field("final_entry", 64'(want.final_entry), 64'(final_entry));
                end
            end
            if (pkt_taken || host_taken)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
                    $display("** arp_host_learning_table: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        arp_item_t it;
        int        seg;
        int        seg_len;
        int        produced;

        rst_n = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_ip[i] = $urandom;
            if (pool_ip[i][31:24] == 8'h00)
                pool_ip[i][31:24] = 8'h01;
            pool_mac[i] = rand48();
            if (pool_mac[i] == 48'h0 || pool_mac[i] == {48{1'b1}})
                pool_mac[i][0] = ~pool_mac[i][0];
        end

        // Directed part, with no random idling on either side.
        item_q.push_back(flush_request());
        item_q.push_back(arp_packet(16'hFFFF, PROTO_TYPE_IPV4, pool_mac[0], pool_ip[0],
                                    pool_mac[1], pool_ip[1], 32'd7, 20'd7));
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, 16'h86DD, pool_mac[0], pool_ip[0],
                                    pool_mac[1], pool_ip[1], 32'd7, 20'd7));
        item_q.push_back(arp_packet(16'h0000, 16'h0000, pool_mac[0], pool_ip[0],
                                    pool_mac[1], pool_ip[1], 32'd7, 20'd7));
        // The same pair as sender and target lands in one slot.
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, 48'h000000000001,
                                    32'h01000000, 48'h000000000001, 32'h01000000,
                                    32'hFFFFFFFF, 20'hFFFFF));
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, rand48(), 32'h00FFFFFF,
                                    {48{1'b1}}, 32'hC0A80001, 32'd100, 20'd5));
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, 48'h0, 32'hC0A80002,
                                    48'hFFFFFFFFFFFE, 32'hFFFFFFFF, 32'h0, 20'h0));
        // A zero timestamp leaves first-seen open for the next sighting.
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, 48'hFFFFFFFFFFFE,
                                    32'hFFFFFFFF, 48'h0A0B0C0D0E0F, 32'hC0A80003,
                                    32'd12345, 20'd999999));
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, 48'h0A0B0C0D0E0F,
                                    32'hC0A80004, 48'h0A0B0C0D0E10, 32'hC0A80003,
                                    32'd12346, 20'd1));
        item_q.push_back(flush_request());
        for (int k = 0; k < DEPTH / 2; k++)
            item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4,
                                        pool_mac[2 * k], pool_ip[2 * k],
                                        pool_mac[2 * k + 1], pool_ip[2 * k + 1],
                                        $urandom, 20'($urandom)));
        // Table is full: three new pairs are dropped, a known pair still updates.
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, pool_mac[32],
                                    pool_ip[32], pool_mac[33], pool_ip[33], 32'd9, 20'd9));
        item_q.push_back(arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, pool_mac[5],
                                    pool_ip[5], pool_mac[34], pool_ip[34], 32'd10, 20'd10));
        // The receiver holds off while packets keep coming, so the block backs up.
        it = flush_request();
        it.hold = 300;
        item_q.push_back(it);

        // Random part, cycling through the idling phases segment by segment.
        produced = 0;
        seg = 0;
        while (produced < 230)
        begin
            case (seg % 4)
                0: begin gen_idle_pct = 0;  gen_stall_pct = 0;  end
                1: begin gen_idle_pct = 51; gen_stall_pct = 0;  end
                2: begin gen_idle_pct = 0;  gen_stall_pct = 51; end
                default: begin gen_idle_pct = 25; gen_stall_pct = 25; end
            endcase
            seg_len = $urandom_range(1, 40);
            for (int k = 0; k < seg_len; k++)
            begin
                it = random_packet();
                if (k == 0 && seg % 3 == 1)
                    it.drain = 1;
                item_q.push_back(it);
            end
            item_q.push_back(flush_request());
            produced += seg_len + 1;
            seg++;
        end
        it = flush_request();
        item_q.push_back(it);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (item_q.size() != 0 || pkt_valid || host_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("** arp_host_learning_table: PASSED **");
        else
            $display("** arp_host_learning_table: FAILED **");
        $finish;
    end

endmodule

>>> files.f
sv/arpl_pkg.sv
sv/arpl_mem.sv
sv/arpl_outreg.sv
sv/arpl_ctrl.sv
sv/arp_host_learning_table.sv
sim/arp_host_learning_table_tb.sv
